@@ rtl/hsv2rgb_pkg.sv @@
// constants and types shared by the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueTurn    = 360;
  localparam int unsigned SectorSpan = 60;
  localparam int unsigned FullScale  = 255;

  // reciprocal multipliers, exact for the operand ranges seen in the pipe
  localparam int unsigned Shift360  = 22;
  localparam int unsigned Recip360  = (1 << Shift360) / HueTurn + 1;
  localparam int unsigned Shift60   = 22;
  localparam int unsigned Recip60   = (1 << Shift60) / SectorSpan + 1;
  localparam int unsigned Shift255  = 24;
  localparam int unsigned Recip255  = (1 << Shift255) / FullScale + 1;

  localparam int unsigned NumStages = 7;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_e;

endpackage

`default_nettype wire

@@ rtl/hsv_to_rgb_converter.sv @@
// hsv to rgb pixel converter, seven stage pipeline
// throughput: one item per clock while the output is not stalled; each stage holds one item and its valid bit
// a stalled output back-pressures stage by stage, so empty stages still fill
// reset clears only the stage valid bits; data registers are not reset
`default_nettype none

module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // hue[15:0], saturation[23:16], brightness[31:24]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o   // red[7:0], green[15:8], blue[23:16]
);

  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   ld;

  // a stage may load when empty or when its item moves on
  always_comb begin
    ld[NumStages] = m_axis_tready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = ld[0];

  logic [15:0] in_hue;
  logic [7:0]  in_sat;
  logic [7:0]  in_val;
  assign in_hue = s_axis_tdata_i[15:0];
  assign in_sat = s_axis_tdata_i[23:16];
  assign in_val = s_axis_tdata_i[31:24];

  // stage 0: hue / 360 by reciprocal
  logic [29:0] hue_prod;
  logic [15:0] st0_hue_q;
  logic [7:0]  st0_quot_q, st0_sat_q, st0_val_q;
  assign hue_prod = 30'(in_hue) * 30'(Recip360);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      st0_hue_q  <= in_hue;
      st0_quot_q <= 8'(hue_prod >> Shift360);
      st0_sat_q  <= in_sat;
      st0_val_q  <= in_val;
    end
  end

  // stage 1: hue modulo 360
  logic [16:0] hue_diff;
  logic [8:0]  hue_mod;
  logic [8:0]  st1_hmod_q;
  logic [7:0]  st1_sat_q, st1_val_q;
  assign hue_diff = 17'(st0_hue_q) - 17'(st0_quot_q) * 17'(HueTurn);
  assign hue_mod  = (hue_diff >= 17'(HueTurn)) ? 9'(hue_diff - 17'(HueTurn)) : 9'(hue_diff);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      st1_hmod_q <= hue_mod;
      st1_sat_q  <= st0_sat_q;
      st1_val_q  <= st0_val_q;
    end
  end

  // stage 2: sector and remainder
  sector_e     sector;
  logic [8:0]  sec_base;
  logic [5:0]  st2_rem_q;
  sector_e     st2_sector_q;
  logic [7:0]  st2_sat_q, st2_val_q;

  always_comb begin
    if (st1_hmod_q >= 9'(5 * SectorSpan)) begin
      sector   = SEC_MAG_RED;
      sec_base = 9'(5 * SectorSpan);
    end else if (st1_hmod_q >= 9'(4 * SectorSpan)) begin
      sector   = SEC_BLU_MAG;
      sec_base = 9'(4 * SectorSpan);
    end else if (st1_hmod_q >= 9'(3 * SectorSpan)) begin
      sector   = SEC_CYN_BLU;
      sec_base = 9'(3 * SectorSpan);
    end else if (st1_hmod_q >= 9'(2 * SectorSpan)) begin
      sector   = SEC_GRN_CYN;
      sec_base = 9'(2 * SectorSpan);
    end else if (st1_hmod_q >= 9'(SectorSpan)) begin
      sector   = SEC_YEL_GRN;
      sec_base = 9'(SectorSpan);
    end else begin
      sector   = SEC_RED_YEL;
      sec_base = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      st2_sector_q <= sector;
      st2_rem_q    <= 6'(st1_hmod_q - sec_base);
      st2_sat_q    <= st1_sat_q;
      st2_val_q    <= st1_val_q;
    end
  end

  // stage 3: saturation times remainder and its complement
  logic [5:0]  rem_inv;
  logic [13:0] st3_pfall_q, st3_prise_q;
  logic [7:0]  st3_lowf_q, st3_val_q;
  sector_e     st3_sector_q;
  assign rem_inv = 6'(SectorSpan) - st2_rem_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      st3_pfall_q  <= 14'(st2_sat_q) * 14'(st2_rem_q);
      st3_prise_q  <= 14'(st2_sat_q) * 14'(rem_inv);
      st3_lowf_q   <= 8'(FullScale) - st2_sat_q;
      st3_val_q    <= st2_val_q;
      st3_sector_q <= st2_sector_q;
    end
  end

  // stage 4: divide by 60, form the scale factors
  logic [30:0] fall_div, rise_div;
  logic [7:0]  st4_fallf_q, st4_risef_q, st4_lowf_q, st4_val_q;
  sector_e     st4_sector_q;
  assign fall_div = 31'(st3_pfall_q) * 31'(Recip60);
  assign rise_div = 31'(st3_prise_q) * 31'(Recip60);

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      st4_fallf_q  <= 8'(FullScale) - 8'(fall_div >> Shift60);
      st4_risef_q  <= 8'(FullScale) - 8'(rise_div >> Shift60);
      st4_lowf_q   <= st3_lowf_q;
      st4_val_q    <= st3_val_q;
      st4_sector_q <= st3_sector_q;
    end
  end

  // stage 5: brightness times factors
  logic [15:0] st5_low_q, st5_fall_q, st5_rise_q;
  logic [7:0]  st5_val_q;
  sector_e     st5_sector_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      st5_low_q    <= 16'(st4_val_q) * 16'(st4_lowf_q);
      st5_fall_q   <= 16'(st4_val_q) * 16'(st4_fallf_q);
      st5_rise_q   <= 16'(st4_val_q) * 16'(st4_risef_q);
      st5_val_q    <= st4_val_q;
      st5_sector_q <= st4_sector_q;
    end
  end

  // stage 6: divide by 255 and route levels to channels
  logic [32:0] low_div, fallv_div, risev_div;
  logic [7:0]  lvl_low, lvl_fall, lvl_rise;
  logic [7:0]  red_d, green_d, blue_d;
  logic [7:0]  red_q, green_q, blue_q;
  assign low_div   = 33'(st5_low_q) * 33'(Recip255);
  assign fallv_div = 33'(st5_fall_q) * 33'(Recip255);
  assign risev_div = 33'(st5_rise_q) * 33'(Recip255);
  assign lvl_low   = 8'(low_div >> Shift255);
  assign lvl_fall  = 8'(fallv_div >> Shift255);
  assign lvl_rise  = 8'(risev_div >> Shift255);

  always_comb begin
    case (st5_sector_q)
      SEC_RED_YEL: begin
        red_d = st5_val_q; green_d = lvl_rise; blue_d = lvl_low;
      end
      SEC_YEL_GRN: begin
        red_d = lvl_fall; green_d = st5_val_q; blue_d = lvl_low;
      end
      SEC_GRN_CYN: begin
        red_d = lvl_low; green_d = st5_val_q; blue_d = lvl_rise;
      end
      SEC_CYN_BLU: begin
        red_d = lvl_low; green_d = lvl_fall; blue_d = st5_val_q;
      end
      SEC_BLU_MAG: begin
        red_d = lvl_rise; green_d = lvl_low; blue_d = st5_val_q;
      end
      default: begin
        red_d = st5_val_q; green_d = lvl_low; blue_d = lvl_fall;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[NumStages-1];
  assign m_axis_tdata_o  = {blue_q, green_q, red_q};

  // input stalls only when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (st1_hmod_q < 9'(HueTurn)))
    else $error("hue reduction out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (st2_rem_q < 6'(SectorSpan)))
    else $error("sector remainder out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[5] && !ld[6]) |=> (vld_q[5] && $stable(st5_low_q) && $stable(st5_sector_q)))
    else $error("stalled stage lost its item");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the hsv to rgb converter: directed table, random pixels, self-checking
`timescale 1ns / 1ps

module tb_top;
  import hsv2rgb_pkg::*;

  localparam int unsigned NumDirected   = 24;
  localparam int unsigned NumBlocks     = 9;
  localparam int unsigned BlockItems    = 150;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned WatchdogLimit = 1000;

  // fields from the highest bit down, same layout as the stream data
  typedef struct packed {
    logic [7:0]  brightness;
    logic [7:0]  saturation;
    logic [15:0] hue;
  } hsv_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    bit          has_typed;
    rgb_t        typed_rgb;
  } pixel_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // hue[15:0], saturation[23:16], brightness[31:24]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;   // red[7:0], green[15:8], blue[23:16]

  rgb_t        pending_rgb[$];
  int unsigned mismatch_count = 0;
  int unsigned pixels_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned grey_pixels    = 0;
  int unsigned wrapped_pixels = 0;
  int unsigned idle_cycles    = 0;
  bit          sender_gaps_en = 1'b1;
  bit          sink_stalls_en = 1'b1;

  // grey, primaries, hue wrap and zero brightness are typed in; the rest is predicted
  pixel_case_t directed_cases [NumDirected] = '{
    '{16'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'd0,     8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{16'd65535, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
    '{16'd0,     8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{16'd120,   8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{16'd240,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{16'd0,     8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{16'd360,   8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{16'd60,    8'd255, 8'd255, 1'b0, '0},
    '{16'd180,   8'd255, 8'd255, 1'b0, '0},
    '{16'd300,   8'd255, 8'd255, 1'b0, '0},
    '{16'd59,    8'd255, 8'd255, 1'b0, '0},
    '{16'd359,   8'd200, 8'd255, 1'b0, '0},
    '{16'd719,   8'd128, 8'd200, 1'b0, '0},
    '{16'd65535, 8'd255, 8'd255, 1'b0, '0},
    '{16'd30,    8'd1,   8'd255, 1'b0, '0},
    '{16'd90,    8'd128, 8'd128, 1'b0, '0},
    '{16'd150,   8'd255, 8'd1,   1'b0, '0},
    '{16'd210,   8'd100, 8'd77,  1'b0, '0},
    '{16'd270,   8'd254, 8'd254, 1'b0, '0},
    '{16'd330,   8'd170, 8'd85,  1'b0, '0},
    '{16'd65520, 8'd255, 8'd255, 1'b0, '0},
    '{16'hAAAA,  8'h55,  8'hAA,  1'b0, '0},
    '{16'h5555,  8'hAA,  8'h55,  1'b0, '0}
  };

  hsv_to_rgb_converter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rgb_t hsv_to_rgb(hsv_t px);
    int unsigned h, s, v, rem, low, fall, rise;
    sector_e     sector;
    rgb_t        rgb;
    h = px.hue % HueTurn;
    s = px.saturation;
    v = px.brightness;
    if (s == 0) begin
      rgb = '{v[7:0], v[7:0], v[7:0]};
    end else begin
      sector = sector_e'(h / SectorSpan);
      rem    = h % SectorSpan;
      low    = v * (FullScale - s) / FullScale;
      fall   = v * (FullScale - (s * rem) / SectorSpan) / FullScale;
      rise   = v * (FullScale - (s * (SectorSpan - rem)) / SectorSpan) / FullScale;
      case (sector)
        SEC_RED_YEL: rgb = '{low[7:0],  rise[7:0], v[7:0]};
        SEC_YEL_GRN: rgb = '{low[7:0],  v[7:0],    fall[7:0]};
        SEC_GRN_CYN: rgb = '{rise[7:0], v[7:0],    low[7:0]};
        SEC_CYN_BLU: rgb = '{v[7:0],    fall[7:0], low[7:0]};
        SEC_BLU_MAG: rgb = '{v[7:0],    low[7:0],  rise[7:0]};
        default:     rgb = '{fall[7:0], low[7:0],  v[7:0]};
      endcase
    end
    return rgb;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_pixel(input hsv_t px, input bit has_typed, input rgb_t typed_rgb);
    if (sender_gaps_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_rgb.push_back(has_typed ? typed_rgb : hsv_to_rgb(px));
    pixels_sent++;
    if (px.saturation == 0) grey_pixels++;
    if (px.hue >= HueTurn) wrapped_pixels++;
    @(negedge clk_i);
  endtask

  function automatic hsv_t random_pixel();
    hsv_t px;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 4) px.hue = 16'($urandom);
    else if (sel < 6) px.hue = 16'(SectorSpan * $urandom_range(0, 5) + $urandom_range(0, 1) * 59);
    else px.hue = 16'($urandom_range(0, HueTurn - 1));
    sel = $urandom_range(0, 15);
    if (sel < 2) px.saturation = 8'd0;
    else if (sel < 4) px.saturation = 8'd255;
    else if (sel == 4) px.saturation = 8'd1;
    else px.saturation = 8'($urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) px.brightness = 8'd0;
    else if (sel == 1) px.brightness = 8'd255;
    else px.brightness = 8'($urandom);
    return px;
  endfunction

  task automatic check_channel(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    rgb_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_rgb.size() == 0) begin
        $error("unexpected item on output: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        mismatch_count++;
      end else begin
        want = pending_rgb.pop_front();
        check_channel("red", want.red, got.red);
        check_channel("green", want.green, got.green);
        check_channel("blue", want.blue, got.blue);
        pixels_checked++;
      end
    end
  end

  // output back-pressure in short bursts
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_stalls_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // ends the run if no item moves on either side for too long
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    hsv_t px;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_cases[i]) begin
      px = '{directed_cases[i].brightness, directed_cases[i].saturation,
             directed_cases[i].hue};
      send_pixel(px, directed_cases[i].has_typed, directed_cases[i].typed_rgb);
    end

    for (int b = 0; b < NumBlocks; b++) begin
      // some blocks run at full rate, and the last one has no idling at all
      sender_gaps_en = (b % 3 != 2) && (b < NumBlocks - 1);
      sink_stalls_en = (b % 3 != 2) && (b < NumBlocks - 1);
      if (b == 4) begin
        s_axis_tvalid_i <= 1'b0;
        while (pending_rgb.size() != 0) @(negedge clk_i);
      end
      repeat (BlockItems) begin
        px = random_pixel();
        send_pixel(px, 1'b0, '0);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d pixels (%0d grey, %0d with hue wrapped), %0d results checked",
             pixels_sent, grey_pixels, wrapped_pixels, pixels_checked);
    $display("all six sectors and both handshake sides exercised with and without idling");
    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
tb/tb_top.sv
